// ===== rtl/adsr_pkg.sv =====
// Shared constants for the ADSR oscillator voice: field widths, opcodes,
// waveform and register codes. No dependencies.
package adsr_pkg;

    localparam int unsigned PITCH_W   = 16;
    localparam int unsigned LEN_W     = 24;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WAVE_W    = 3;
    localparam int unsigned LVL_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LFSR_W    = 32;

    // serial divider: 18 quotient bits, 40-bit dividend, 24-bit divisor
    localparam int unsigned QUOT_W    = 18;
    localparam int unsigned DVD_W     = 40;
    localparam int unsigned DVS_W     = 24;
    localparam int unsigned ENV_W     = 17;
    localparam int unsigned OSC_SHIFT = 17;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_NOTE = 1'b1;

    localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_NOISE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_EN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd5;

    localparam logic [LFSR_W-1:0] LFSR_MASK   = 32'h8020_0003;
    localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== rtl/adsr_oscillator_voice_unit.sv =====
// One synthesizer voice: phase-accumulator oscillator with ADSR envelope.
// Depends on adsr_pkg; holds the quarter-sine ROM and a bit-serial divider.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one transaction per
//   command: operation 1 starts a note (pitch, length), operation 0 is a
//   sample tick. A note start yields no result. Each tick yields exactly one
//   result on the output channel
//   (o_out_valid / i_out_ready): o_sample in signed Q1.15 and o_voice_active.
//   A silent voice sends its tick straight to the output stage. Otherwise
//   saw, triangle and sine run a phase division before the ROM lookup and
//   waveform select; square, noise and unused codes skip it. With the
//   envelope on, the attack, decay and release segments add a second
//   division. The restoring divider retires one quotient bit per cycle,
//   18 per division. Ticks are processed one at a time.
//   A finished result sits in an output register; the next transaction is
//   taken while it waits. If the receiver stalls, the following result holds
//   in the sequencer until the output register frees up.
//   Synchronous reset restores the register defaults (square wave, envelope
//   off, sustain at one half), silences the voice and sets the noise LFSR to
//   all ones. Configuration writes are taken in any cycle, no handshake.
module adsr_oscillator_voice_unit
    import adsr_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int RATE_HZ          = 44100
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_operation,
    input  logic [PITCH_W-1:0]         i_pitch_hz,
    input  logic [LEN_W-1:0]           i_length_samples,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_voice_active,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int PH_W  = $clog2(RATE_HZ + 1);
    localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SI_W  = $clog2(4 * SINE_TABLE_DEPTH + 1);
    localparam int CNT_W = $clog2(QUOT_W + 1);

    localparam logic [PH_W-1:0] RATE      = PH_W'(RATE_HZ);
    localparam logic [SI_W-1:0] SI_D1     = SI_W'(SINE_TABLE_DEPTH);
    localparam logic [SI_W-1:0] SI_D2     = SI_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [SI_W-1:0] SI_D3     = SI_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [SI_W-1:0] SI_D4     = SI_W'(4 * SINE_TABLE_DEPTH);
    localparam logic [AW-1:0]   ROM_TOP   = AW'(SINE_TABLE_DEPTH);
    localparam logic [DVD_W-1:0] SINE_MUL = DVD_W'(4 * SINE_TABLE_DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_OSC_DIV = 4'd1;
    localparam logic [3:0] S_ROM     = 4'd2;
    localparam logic [3:0] S_OSC_SEL = 4'd3;
    localparam logic [3:0] S_ENV_ATK = 4'd4;
    localparam logic [3:0] S_ENV_DEC = 4'd5;
    localparam logic [3:0] S_ENV_REL = 4'd6;
    localparam logic [3:0] S_ENV_MUL = 4'd7;
    localparam logic [3:0] S_ENV_DIV = 4'd8;
    localparam logic [3:0] S_ENV_SEL = 4'd9;
    localparam logic [3:0] S_SCALE   = 4'd10;
    localparam logic [3:0] S_FINISH  = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;

    localparam logic [2:0] SEG_ATK = 3'd0;
    localparam logic [2:0] SEG_DEC = 3'd1;
    localparam logic [2:0] SEG_SUS = 3'd2;
    localparam logic [2:0] SEG_REL = 3'd3;
    localparam logic [2:0] SEG_OFF = 3'd4;

    // Taylor series to x^11, each term truncated, rounded to Q15
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (sum + 64'sd16384) >>> 15;
        if (rnd > 64'sd32767) begin
            rnd = 64'sd32767;
        end
        return rnd[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

    logic [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar gk = 0; gk <= SINE_TABLE_DEPTH; gk++) begin : g_rom
        assign sine_rom[gk] = quarter_sine(gk);
    end

    // configuration
    logic [WAVE_W-1:0] r_waveform;
    logic              r_env_en;
    logic [LEN_W-1:0]  r_attack;
    logic [LEN_W-1:0]  r_decay;
    logic [LVL_W-1:0]  r_sustain;
    logic [LEN_W-1:0]  r_release;

    // voice state
    logic              r_sounding;
    logic [TIME_W-1:0] r_elapsed;
    logic [LEN_W-1:0]  r_note_end;
    logic [PH_W-1:0]   r_phase;
    logic [PH_W-1:0]   r_step;
    logic [LFSR_W-1:0] r_lfsr;

    // sequencer and serial divider
    logic [3:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_dq;
    logic [DVS_W-1:0]  r_dvs;

    // per-sample working registers
    logic [SAMPLE_W-1:0]        r_rom_q;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_v;
    logic                       r_atk_b;
    logic [TIME_W-1:0]          r_m;
    logic                       r_dec_in;
    logic                       r_sus_b;
    logic [TIME_W-1:0]          r_r;
    logic [2:0]                 r_seg;
    logic [ENV_W-1:0]           r_env;
    logic signed [33:0]         r_prod;
    logic signed [SAMPLE_W-1:0] r_res_sample;
    logic                       r_res_active;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_active;

    logic [DVD_W-1:0]  ld_n;
    logic [DVS_W-1:0]  ld_d;
    logic [40:0]       mul_dec;
    logic [40:0]       mul_rel;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W+1:0]  rem_dif;
    logic              div_last;

    logic [SI_W-1:0]   si;
    logic [1:0]        quad;
    logic [AW-1:0]     si_off;
    logic [AW-1:0]     rom_addr;

    logic [LFSR_W-1:0]   lfsr_next;
    logic signed [19:0]  osc_val;
    logic signed [33:0]  prod_rnd;
    logic signed [19:0]  scaled;
    logic [PH_W:0]       phase_sum;
    logic [PH_W-1:0]     phase_next;
    logic                use_div;
    logic                out_free;

    assign mul_dec = r_m[LEN_W-1:0] * (17'h10000 - {1'b0, r_sustain});
    assign mul_rel = r_r[LEN_W-1:0] * r_sustain;

    always_comb begin
        if (r_state == S_IDLE) begin
            if (r_waveform == WAVE_SINE) begin
                ld_n = DVD_W'(r_phase) * SINE_MUL;
            end else begin
                ld_n = DVD_W'(r_phase) << OSC_SHIFT;
            end
            ld_d = DVS_W'(RATE);
        end else begin
            unique case (r_seg)
                SEG_ATK: begin
                    ld_n = {r_elapsed[LEN_W-1:0], 16'd0};
                    ld_d = r_attack;
                end
                SEG_DEC: begin
                    ld_n = mul_dec[DVD_W-1:0];
                    ld_d = r_decay;
                end
                SEG_REL: begin
                    ld_n = mul_rel[DVD_W-1:0];
                    ld_d = r_release;
                end
                default: begin
                    ld_n = '0;
                    ld_d = r_release;
                end
            endcase
        end
    end

    // one restoring step: shift in the next dividend bit, try the subtract
    assign rem_sh   = {r_rem, r_dq[QUOT_W-1]};
    assign rem_dif  = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign div_last = (r_cnt == CNT_W'(QUOT_W - 1));

    // quadrant and offset of the sine index
    assign si = r_dq[SI_W-1:0];
    always_comb begin
        priority if (si >= SI_D4) begin
            quad   = 2'd0;
            si_off = '0;
        end else if (si >= SI_D3) begin
            quad   = 2'd3;
            si_off = AW'(si - SI_D3);
        end else if (si >= SI_D2) begin
            quad   = 2'd2;
            si_off = AW'(si - SI_D2);
        end else if (si >= SI_D1) begin
            quad   = 2'd1;
            si_off = AW'(si - SI_D1);
        end else begin
            quad   = 2'd0;
            si_off = AW'(si);
        end
    end
    assign rom_addr = quad[0] ? (ROM_TOP - si_off) : si_off;

    assign lfsr_next = r_lfsr[0] ? ({1'b0, r_lfsr[LFSR_W-1:1]} ^ LFSR_MASK)
                                 : {1'b0, r_lfsr[LFSR_W-1:1]};

    always_comb begin
        unique case (r_waveform)
            WAVE_SAW: osc_val = $signed({3'b000, r_dq[QUOT_W-1:1]}) - 20'sd32768;
            WAVE_TRI: begin
                if (r_dq < 18'd32768) begin
                    osc_val = $signed({2'b00, r_dq});
                end else if (r_dq <= 18'd98304) begin
                    osc_val = 20'sd65536 - $signed({2'b00, r_dq});
                end else begin
                    osc_val = $signed({2'b00, r_dq}) - 20'sd131072;
                end
            end
            WAVE_SINE: begin
                if (r_neg) begin
                    osc_val = -$signed({4'b0000, r_rom_q});
                end else begin
                    osc_val = $signed({4'b0000, r_rom_q});
                end
            end
            WAVE_SQUARE: begin
                if ({r_phase, 1'b0} < (PH_W + 1)'(RATE_HZ)) begin
                    osc_val = -20'sd32768;
                end else begin
                    osc_val = 20'sd32767;
                end
            end
            WAVE_NOISE: osc_val = $signed({{4{lfsr_next[15]}}, lfsr_next[15:0]});
            default:    osc_val = '0;
        endcase
    end

    assign prod_rnd = r_prod + 34'sd32768;
    assign scaled   = $signed({{2{prod_rnd[33]}}, prod_rnd[33:16]});

    assign phase_sum  = {1'b0, r_phase} + {1'b0, r_step};
    assign phase_next = (phase_sum > {1'b0, RATE}) ? PH_W'(phase_sum - {1'b0, RATE})
                                                   : PH_W'(phase_sum);

    assign use_div  = (r_waveform == WAVE_SAW) || (r_waveform == WAVE_TRI)
                   || (r_waveform == WAVE_SINE);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform  <= WAVE_SQUARE;
            r_env_en    <= 1'b0;
            r_attack    <= '0;
            r_decay     <= '0;
            r_sustain   <= 16'h8000;
            r_release   <= '0;
            r_sounding  <= 1'b0;
            r_elapsed   <= '0;
            r_note_end  <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_lfsr      <= '1;
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one loads this cycle
            if (i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_operation == OP_NOTE) begin
                            r_step     <= (i_pitch_hz > PITCH_W'(RATE_HZ)) ? RATE
                                                                           : PH_W'(i_pitch_hz);
                            r_note_end <= i_length_samples;
                            r_elapsed  <= '0;
                            r_phase    <= '0;
                            r_sounding <= 1'b1;
                        end else if (!r_sounding) begin
                            r_res_sample <= '0;
                            r_res_active <= 1'b0;
                            r_state      <= S_EMIT;
                        end else if (use_div) begin
                            r_rem   <= DVS_W'(ld_n[DVD_W-1:QUOT_W]);
                            r_dq    <= ld_n[QUOT_W-1:0];
                            r_dvs   <= ld_d;
                            r_cnt   <= '0;
                            r_state <= S_OSC_DIV;
                        end else begin
                            r_state <= S_ROM;
                        end
                    end
                end
                S_OSC_DIV, S_ENV_DIV: begin
                    if (!rem_dif[DVS_W+1]) begin
                        r_rem <= rem_dif[DVS_W-1:0];
                    end else begin
                        r_rem <= rem_sh[DVS_W-1:0];
                    end
                    r_dq  <= {r_dq[QUOT_W-2:0], !rem_dif[DVS_W+1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (div_last) begin
                        r_state <= (r_state == S_OSC_DIV) ? S_ROM : S_ENV_SEL;
                    end
                end
                S_ROM: begin
                    r_rom_q <= sine_rom[rom_addr];
                    r_neg   <= quad[1];
                    r_state <= S_OSC_SEL;
                end
                S_OSC_SEL: begin
                    r_v <= sat16(osc_val);
                    if (r_waveform == WAVE_NOISE) begin
                        r_lfsr <= lfsr_next;
                    end
                    r_state <= r_env_en ? S_ENV_ATK : S_FINISH;
                end
                S_ENV_ATK: begin
                    {r_atk_b, r_m} <= {1'b0, r_elapsed} - (TIME_W + 1)'(r_attack);
                    r_state        <= S_ENV_DEC;
                end
                S_ENV_DEC: begin
                    r_dec_in       <= (r_m < TIME_W'(r_decay));
                    {r_sus_b, r_r} <= {1'b0, r_elapsed} - (TIME_W + 1)'(r_note_end);
                    r_state        <= S_ENV_REL;
                end
                S_ENV_REL: begin
                    priority if (r_atk_b) begin
                        r_seg <= SEG_ATK;
                    end else if (r_dec_in) begin
                        r_seg <= SEG_DEC;
                    end else if (r_sus_b) begin
                        r_seg <= SEG_SUS;
                    end else if (r_r < TIME_W'(r_release)) begin
                        r_seg <= SEG_REL;
                    end else begin
                        r_seg <= SEG_OFF;
                    end
                    r_state <= S_ENV_MUL;
                end
                S_ENV_MUL: begin
                    unique case (r_seg)
                        SEG_ATK, SEG_DEC, SEG_REL: begin
                            r_rem   <= DVS_W'(ld_n[DVD_W-1:QUOT_W]);
                            r_dq    <= ld_n[QUOT_W-1:0];
                            r_dvs   <= ld_d;
                            r_cnt   <= '0;
                            r_state <= S_ENV_DIV;
                        end
                        SEG_SUS: begin
                            r_env   <= {1'b0, r_sustain};
                            r_state <= S_SCALE;
                        end
                        default: begin
                            r_env   <= '0;
                            r_state <= S_SCALE;
                        end
                    endcase
                end
                S_ENV_SEL: begin
                    unique case (r_seg)
                        SEG_ATK: r_env <= {1'b0, r_dq[15:0]};
                        SEG_DEC: r_env <= 17'h10000 - r_dq[ENV_W-1:0];
                        default: r_env <= {1'b0, r_sustain} - r_dq[ENV_W-1:0];
                    endcase
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= r_v * $signed({1'b0, r_env});
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (r_env_en) begin
                        r_res_sample <= sat16(scaled);
                        r_res_active <= (r_seg != SEG_OFF);
                        r_sounding   <= (r_seg != SEG_OFF);
                    end else begin
                        r_res_sample <= r_v;
                        r_res_active <= (r_elapsed < TIME_W'(r_note_end));
                        r_sounding   <= (r_elapsed < TIME_W'(r_note_end));
                    end
                    r_phase <= phase_next;
                    if (r_elapsed != '1) begin
                        r_elapsed <= r_elapsed + 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_res_sample;
                        r_out_active <= r_res_active;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WAVEFORM: begin
                        r_waveform <= i_cfg_data[WAVE_W-1:0];
                        r_sounding <= 1'b0;
                    end
                    REG_ENV_EN:  r_env_en  <= i_cfg_data[0];
                    REG_ATTACK:  r_attack  <= i_cfg_data[LEN_W-1:0];
                    REG_DECAY:   r_decay   <= i_cfg_data[LEN_W-1:0];
                    REG_SUSTAIN: r_sustain <= i_cfg_data[LVL_W-1:0];
                    REG_RELEASE: r_release <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_voice_active = r_out_active;

endmodule

// ===== rtl/adsr_chk.sv =====
// Port-level checks for the ADSR oscillator voice, bound to the top level.
// Depends on adsr_pkg for opcodes and field widths.
module adsr_chk
    import adsr_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_operation,
    input logic [PITCH_W-1:0]         i_pitch_hz,
    input logic [LEN_W-1:0]           i_length_samples,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] o_sample,
    input logic                       o_voice_active,
    input logic                       i_cfg_we,
    input logic [CFG_IDX_W-1:0]       i_cfg_index,
    input logic [CFG_W-1:0]           i_cfg_data
);

    logic in_xact;

    assign in_xact = i_in_valid && o_in_ready;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a tick transaction drops ready in the cycle after it is taken
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && (i_operation == OP_TICK) |=> !o_in_ready)
        else $error("ready held across a tick");

    // a note start yields no result and leaves the voice ready
    a_note_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && (i_operation == OP_NOTE) |=> o_in_ready)
        else $error("note start stalled the input");

    // stalled result keeps valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sample) && $stable(o_voice_active))
        else $error("stalled result changed");

endmodule

bind adsr_oscillator_voice_unit adsr_chk u_adsr_chk (.*);

// ===== sim/adsr_voice_monitor.sv =====
// Channel monitor for the ADSR oscillator voice: keeps its own model of the
// voice, predicts one sample per tick and compares each delivered result.
// Depends on adsr_pkg for widths, opcodes, waveform and register codes.
module adsr_voice_monitor
    import adsr_pkg::*;
#(
    parameter int SINE_DEPTH = 256,
    parameter int RATE       = 44100
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_operation,
    input  logic [PITCH_W-1:0]         i_pitch_hz,
    input  logic [LEN_W-1:0]           i_length_samples,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_voice_active,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                active;
    } voice_out_t;

    voice_out_t expected_samples[$];
    int         mismatches;

    // register copy
    logic [WAVE_W-1:0] wave_sel;
    logic              env_on;
    logic [LEN_W-1:0]  attack_len;
    logic [LEN_W-1:0]  decay_len;
    logic [LVL_W-1:0]  sustain_lvl;
    logic [LEN_W-1:0]  release_len;

    // voice state copy
    logic              playing;
    logic [TIME_W-1:0] elapsed;
    logic [LEN_W-1:0]  note_len;
    logic [15:0]       phase_acc;
    logic [15:0]       phase_step;
    logic [LFSR_W-1:0] lfsr;

    function automatic int clamp_q15(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // quarter-wave entry: truncated Taylor series of sin in Q30, rounded to Q15
    function automatic int quarter_entry(longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x = (HALF_PI_Q30 * k) / 64'(SINE_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        return clamp_q15((acc + 16384) >>> 15);
    endfunction

    function automatic int wave_value();
        longint unsigned p;
        longint unsigned idx;
        longint          x;
        int unsigned     quad;
        int unsigned     ofs;
        logic            fb;
        p = 64'(phase_acc);
        case (wave_sel)
            WAVE_SAW: begin
                return clamp_q15(longint'((64'd65536 * p) / 64'(RATE)) - 32768);
            end
            WAVE_TRI: begin
                x = longint'((64'd131072 * p) / 64'(RATE));
                if (x < 32768) return clamp_q15(x);
                if (x <= 98304) return clamp_q15(65536 - x);
                return clamp_q15(x - 131072);
            end
            WAVE_SINE: begin
                idx = (64'(4 * SINE_DEPTH) * p) / 64'(RATE);
                quad = int'((idx / 64'(SINE_DEPTH)) & 64'd3);
                ofs = int'(idx % 64'(SINE_DEPTH));
                case (quad)
                    0: return quarter_entry(ofs);
                    1: return quarter_entry(SINE_DEPTH - ofs);
                    2: return -quarter_entry(ofs);
                    default: return -quarter_entry(SINE_DEPTH - ofs);
                endcase
            end
            WAVE_SQUARE: begin
                return (64'd2 * p < 64'(RATE)) ? -32768 : 32767;
            end
            WAVE_NOISE: begin
                fb = lfsr[0];
                lfsr = lfsr >> 1;
                if (fb) lfsr ^= LFSR_MASK;
                return int'($signed(lfsr[15:0]));
            end
            default: return 0;
        endcase
    endfunction

    // unsigned Q1.16 envelope gain; silences the voice once the release has run out
    function automatic longint unsigned env_gain();
        longint unsigned n;
        longint unsigned m;
        longint unsigned a;
        longint unsigned d;
        longint unsigned s;
        longint unsigned r;
        n = 64'(elapsed);
        a = 64'(attack_len);
        d = 64'(decay_len);
        s = 64'(sustain_lvl);
        r = 64'(release_len);
        if (n < a) return (n * 64'd65536) / a;
        m = n - a;
        if (m < d) return 64'd65536 - (m * (64'd65536 - s)) / d;
        if (n < 64'(note_len)) return s;
        m = n - 64'(note_len);
        if (m < r) return s - (s * m) / r;
        playing = 1'b0;
        return 64'd0;
    endfunction

    function automatic voice_out_t advance_voice();
        voice_out_t      res;
        int              v;
        longint          prod;
        longint unsigned gain;
        int unsigned     nxt;
        v = 0;
        if (playing) begin
            v = wave_value();
            if (env_on) begin
                gain = env_gain();
                prod = longint'(v) * longint'(gain) + 32768;
                v = clamp_q15(prod >>> 16);
            end else if (elapsed >= 32'(note_len)) begin
                playing = 1'b0;
            end
            nxt = 32'(phase_acc) + 32'(phase_step);
            if (nxt > 32'(RATE)) nxt -= 32'(RATE);
            phase_acc = 16'(nxt);
            if (elapsed != '1) elapsed++;
        end
        res.sample = 16'(v);
        res.active = playing;
        return res;
    endfunction

    function automatic void start_note(logic [PITCH_W-1:0] pitch, logic [LEN_W-1:0] len);
        phase_step = (32'(pitch) > 32'(RATE)) ? 16'(RATE) : pitch;
        note_len = len;
        elapsed = '0;
        phase_acc = '0;
        playing = 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_WAVEFORM: begin
                wave_sel = data[WAVE_W-1:0];
                playing = 1'b0;
            end
            REG_ENV_EN:  env_on = data[0];
            REG_ATTACK:  attack_len = data[LEN_W-1:0];
            REG_DECAY:   decay_len = data[LEN_W-1:0];
            REG_SUSTAIN: sustain_lvl = data[LVL_W-1:0];
            REG_RELEASE: release_len = data[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        voice_out_t want;
        if (!i_rst_n) begin
            wave_sel = WAVE_SQUARE;
            env_on = 1'b0;
            attack_len = '0;
            decay_len = '0;
            sustain_lvl = 16'd32768;
            release_len = '0;
            playing = 1'b0;
            elapsed = '0;
            note_len = '0;
            phase_acc = '0;
            phase_step = '0;
            lfsr = '1;
            expected_samples.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: result with no tick outstanding: sample %0d active %0b",
                             $time, i_sample, i_voice_active);
                    mismatches++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_sample !== want.sample) begin
                        $display("%0t: sample mismatch: expected %0d actual %0d",
                                 $time, $signed(want.sample), i_sample);
                        mismatches++;
                    end
                    if (i_voice_active !== want.active) begin
                        $display("%0t: voice_active mismatch: expected %0b actual %0b",
                                 $time, want.active, i_voice_active);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_NOTE) start_note(i_pitch_hz, i_length_samples);
                else expected_samples.push_back(advance_voice());
            end
        end
        o_pending <= expected_samples.size();
        o_errors <= mismatches;
    end

endmodule

// ===== sim/adsr_oscillator_voice_unit_test.sv =====
// Top of the ADSR oscillator voice test: clock, reset, register setup and
// tick/note stimulus with random idling; checking lives in adsr_voice_monitor.
// Depends on adsr_pkg, adsr_oscillator_voice_unit and adsr_voice_monitor.
module adsr_oscillator_voice_unit_test;
    import adsr_pkg::*;

    localparam int SINE_DEPTH   = 256;
    localparam int RATE         = 44100;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_ITEMS = 900;
    localparam int LIMIT_TIME   = 12_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [WAVE_W-1:0]    WAVE_UNUSED  = 3'd5;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       operation = OP_TICK;
    logic [PITCH_W-1:0]         pitch_hz = '0;
    logic [LEN_W-1:0]           length_samples = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       voice_active;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    int pending;
    int errors;
    int items_sent = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    adsr_oscillator_voice_unit #(
        .SINE_TABLE_DEPTH(SINE_DEPTH),
        .RATE_HZ(RATE)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_operation(operation),
        .i_pitch_hz(pitch_hz),
        .i_length_samples(length_samples),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_sample(sample),
        .o_voice_active(voice_active),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    adsr_voice_monitor #(
        .SINE_DEPTH(SINE_DEPTH),
        .RATE(RATE)
    ) monitor (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_ready(in_ready),
        .i_operation(operation),
        .i_pitch_hz(pitch_hz),
        .i_length_samples(length_samples),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_sample(sample),
        .i_voice_active(voice_active),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_pending(pending),
        .o_errors(errors)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("FAIL adsr_oscillator_voice_unit");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= no_idle || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic send_item(logic op, logic [PITCH_W-1:0] pitch, logic [LEN_W-1:0] len);
        while (!no_idle && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        pitch_hz <= pitch;
        length_samples <= len;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic tick();
        send_item(OP_TICK, PITCH_W'($urandom), LEN_W'($urandom));
    endtask

    // wait out every outstanding tick, then let a late note start settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_voice(logic [WAVE_W-1:0] wave, logic env, logic [LEN_W-1:0] a,
                                 logic [LEN_W-1:0] d, logic [LVL_W-1:0] s,
                                 logic [LEN_W-1:0] r);
        write_reg(REG_WAVEFORM, CFG_W'(wave));
        write_reg(REG_ENV_EN, CFG_W'(env));
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, CFG_W'(s));
        write_reg(REG_RELEASE, r);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [WAVE_W-1:0] pick_wave();
        if ($urandom_range(9) == 0) return WAVE_W'($urandom_range(5, 7));
        return WAVE_W'($urandom_range(0, 4));
    endfunction

    // mostly short segments so every envelope stage is reached in a few ticks
    function automatic logic [LEN_W-1:0] pick_span();
        logic [LEN_W-1:0] v;
        case ($urandom_range(19))
            0: v = '0;
            1: v = '1;
            2, 3: v = LEN_W'($urandom);
            4: v = LEN_W'($urandom_range(13, 300));
            default: v = LEN_W'($urandom_range(12));
        endcase
        return v;
    endfunction

    function automatic logic [LVL_W-1:0] pick_level();
        logic [LVL_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2: v = 16'd1;
            3: v = 16'd32768;
            default: v = LVL_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [PITCH_W-1:0] pick_pitch();
        logic [PITCH_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = PITCH_W'(RATE);
            2: v = PITCH_W'($urandom);
            3: v = PITCH_W'($urandom_range(RATE + 1, 65535));
            default: v = PITCH_W'($urandom_range(RATE));
        endcase
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        logic [LEN_W-1:0] v;
        case ($urandom_range(9))
            0: v = '1;
            1, 2: v = LEN_W'($urandom);
            3: v = '0;
            default: v = LEN_W'($urandom_range(20));
        endcase
        return v;
    endfunction

    initial begin
        int phase_no;
        int notes;
        int ticks;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // silent voice with the reset defaults, then a flat square note
        tick();
        tick();
        send_item(OP_NOTE, 16'd11025, 24'd3);
        repeat (5) tick();
        // pitch above the rate saturates
        send_item(OP_NOTE, 16'hFFFF, 24'd2);
        repeat (3) tick();
        drain();

        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        // sustain zero with the note end inside the attack
        program_voice(WAVE_SAW, 1'b1, 24'd2, 24'd2, 16'd0, 24'd2);
        send_item(OP_NOTE, 16'(RATE), 24'd1);
        repeat (8) tick();
        drain();

        // unused waveform code plays silence but runs the voice
        program_voice(WAVE_UNUSED, 1'b0, '0, '0, '1, '1);
        send_item(OP_NOTE, 16'd1000, 24'd2);
        repeat (3) tick();

        phase_no = 0;
        while (items_sent < TARGET_ITEMS) begin
            drain();
            no_idle = (phase_no >= 6 && phase_no < 10);
            program_voice(pick_wave(), $urandom_range(9) < 7, pick_span(), pick_span(),
                          pick_level(), pick_span());
            // stall the output long enough to back the input up
            if (phase_no == 3) hold_req = 1'b1;
            notes = $urandom_range(1, 3);
            repeat (notes) begin
                if ($urandom_range(9) == 0) tick();
                send_item(OP_NOTE, pick_pitch(), pick_length());
                ticks = (phase_no == 3) ? 20 : $urandom_range(0, 35);
                repeat (ticks) tick();
            end
            phase_no++;
        end
        drain();

        if (errors == 0) begin
            $display("PASS adsr_oscillator_voice_unit");
        end else begin
            $display("FAIL adsr_oscillator_voice_unit");
        end
        $finish;
    end

endmodule
